@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block, fbs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge of the clock, held off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication on every rising edge of the clock, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/fbs_pkg.sv @@
// ----------------------------------------------------------------------------
// FIR filter bank select package
// Field widths, default parameter values and request codes.
// ----------------------------------------------------------------------------
package fbs_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int BANK_W   = 2;
   localparam int INDEX_W  = 6;

   localparam int TAPS_DEFAULT      = 63;
   localparam int BANKS_DEFAULT     = 3;
   localparam int FRAC_BITS_DEFAULT = 15;

   typedef enum logic [0:0] {
      OP_FILTER     = 1'b0,
      OP_COEF_WRITE = 1'b1
   } op_type;

endpackage

@@ hw/rtl/fir_filter_bank_select_top.sv @@
// ----------------------------------------------------------------------------
// FIR filter bank select, top level
// Direct-form FIR filter with selectable coefficient banks, one tap per cycle.
// ----------------------------------------------------------------------------
// The request channel (req_) carries either a sample to filter or a coefficient
// write, chosen by req_operation. A coefficient write gives no response.
// A sample request gives one response on the rsp_ channel.
// A sample is worked through one tap per cycle: the history line rotates one
// word per cycle past a single 16 by 16 multiplier, and the coefficient memory
// gives one registered read per cycle. req_ready stays low from an accepted
// sample until its response is registered and rises with rsp_valid, so the
// block takes no request of either kind while a sample is filtered.
// csr_write_enable writes csr_write_data into the bank select register in the
// same cycle; it should only be used while the block is idle.
// Reset clears the history line, marks every coefficient as zero through its
// valid bit and selects bank 0; there is no clearing pass.
// A response waits in its output register until rsp_ready is high. Meanwhile
// the block still accepts coefficient writes and one further sample, whose
// result is held back until the waiting response has been taken.
// ----------------------------------------------------------------------------
module fir_filter_bank_select_top #(
   parameter int TAPS           = fbs_pkg::TAPS_DEFAULT,
   parameter int BANKS          = fbs_pkg::BANKS_DEFAULT,
   parameter int COEF_FRAC_BITS = fbs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [0:0]                          req_operation,
   input  logic signed [fbs_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [fbs_pkg::BANK_W-1:0]          req_coef_bank,
   input  logic [fbs_pkg::INDEX_W-1:0]         req_coef_index,
   input  logic signed [fbs_pkg::COEF_W-1:0]   req_coef_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fbs_pkg::SAMPLE_W-1:0] rsp_filtered_sample,
   output logic                                rsp_saturated,
   input  logic                                csr_write_enable,
   input  logic [fbs_pkg::BANK_W-1:0]          csr_write_data
);
   import fbs_pkg::*;

   localparam int DEPTH  = BANKS * TAPS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TAP_W  = $clog2(TAPS);
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W  = PROD_W + $clog2(TAPS);

   localparam logic signed [ACC_W-1:0] MAX_OUT  = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] MIN_OUT  = ACC_W'(-(2 ** (SAMPLE_W - 1)));
   localparam logic signed [ACC_W-1:0] ROUND_UP = ACC_W'(2 ** COEF_FRAC_BITS - 1);
   localparam logic [TAP_W-1:0]        LAST_TAP = TAP_W'(TAPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic [TAP_W-1:0]            tap_ff, tap_in;
   logic [ADDR_W-1:0]           base_ff, base_in;
   logic [BANK_W-1:0]           bank_select_ff, bank_select_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic                        rsp_sat_ff, rsp_sat_in;

   logic signed [SAMPLE_W-1:0]  line_ff [TAPS];
   logic                        coef_valid_ff [DEPTH];
   logic signed [COEF_W-1:0]    coef_mem [DEPTH];

   logic signed [COEF_W-1:0]    coef_rd_ff;
   logic                        coef_rd_valid_ff;
   logic signed [SAMPLE_W-1:0]  smp_rd_ff;
   logic                        rd_vld_ff, rd_vld_in;
   logic signed [PROD_W-1:0]    prod_ff;
   logic                        mul_vld_ff;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;

   logic                        accept;
   logic                        filter_accept;
   logic                        coef_write;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr;
   logic signed [COEF_W-1:0]    coef_eff;
   logic signed [ACC_W-1:0]     round_adj;
   logic signed [ACC_W-1:0]     quot;
   int                          bank_eff;

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign filter_accept = accept && (req_operation == OP_FILTER);
   assign coef_write    = accept && (req_operation == OP_COEF_WRITE)
                          && (int'(req_coef_bank) < BANKS) && (int'(req_coef_index) < TAPS);
   assign wr_addr       = ADDR_W'(int'(req_coef_bank) * TAPS + int'(req_coef_index));
   assign rd_addr       = base_ff + ADDR_W'(tap_ff);
   assign coef_eff      = coef_rd_valid_ff ? coef_rd_ff : '0;
   assign rd_vld_in     = (state_ff == ST_RUN);
   assign acc_in        = filter_accept ? '0 :
                          (mul_vld_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff);

   assign round_adj = acc_ff[ACC_W-1] ? acc_ff + ROUND_UP : acc_ff;
   assign quot      = round_adj >>> COEF_FRAC_BITS;

   always_comb begin
      bank_eff       = (int'(bank_select_ff) >= BANKS) ? BANKS - 1 : int'(bank_select_ff);
      state_in       = state_ff;
      tap_in         = tap_ff;
      base_in        = base_ff;
      bank_select_in = csr_write_enable ? csr_write_data : bank_select_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_sat_in     = rsp_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (filter_accept) begin
               state_in = ST_RUN;
               tap_in   = LAST_TAP;
               base_in  = ADDR_W'(bank_eff * TAPS);
            end
         end
         ST_RUN: begin
            if (tap_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff - 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (quot > MAX_OUT) begin
                  rsp_sample_in = MAX_OUT[SAMPLE_W-1:0];
                  rsp_sat_in    = 1'b1;
               end else if (quot < MIN_OUT) begin
                  rsp_sample_in = MIN_OUT[SAMPLE_W-1:0];
                  rsp_sat_in    = 1'b1;
               end else begin
                  rsp_sample_in = quot[SAMPLE_W-1:0];
                  rsp_sat_in    = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bank_select_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bank_select_ff <= bank_select_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      tap_ff        <= tap_in;
      base_ff       <= base_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // The history line takes each new sample at its head and rotates once per
   // tap while a sample is filtered, which returns it to its starting order.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            line_ff[i] <= '0;
         end
         for (int i = 0; i < DEPTH; i++) begin
            coef_valid_ff[i] <= 1'b0;
         end
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         if (filter_accept) begin
            line_ff[0] <= req_sample;
            for (int i = 1; i < TAPS; i++) begin
               line_ff[i] <= line_ff[i-1];
            end
         end else if (state_ff == ST_RUN) begin
            line_ff[0] <= line_ff[TAPS-1];
            for (int i = 1; i < TAPS; i++) begin
               line_ff[i] <= line_ff[i-1];
            end
         end
         if (coef_write) begin
            coef_valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_write) begin
         coef_mem[wr_addr] <= req_coef_value;
      end
      coef_rd_ff       <= coef_mem[rd_addr];
      coef_rd_valid_ff <= coef_valid_ff[rd_addr];
      smp_rd_ff        <= line_ff[TAPS-1];
      prod_ff          <= coef_eff * smp_rd_ff;
      acc_ff           <= acc_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

@@ hw/rtl/fbs_checker.sv @@
// ----------------------------------------------------------------------------
// FIR filter bank select checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [0:0]                          req_operation,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [fbs_pkg::SAMPLE_W-1:0] rsp_filtered_sample,
   input logic                                rsp_saturated
);
   import fbs_pkg::*;

   localparam logic signed [SAMPLE_W-1:0] MAX_OUT = SAMPLE_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [SAMPLE_W-1:0] MIN_OUT = SAMPLE_W'(-(2 ** (SAMPLE_W - 1)));

   `ASSERT_CLK(a_rsp_valid_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response withdrawn before it was taken")
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_filtered_sample) && $stable(rsp_saturated), "stalled response changed")
   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, $past(reset) |-> !rsp_valid, "response valid straight after reset")
   `ASSERT_CLK(a_sat_value, clock, reset, rsp_valid && rsp_saturated |-> rsp_filtered_sample == MAX_OUT || rsp_filtered_sample == MIN_OUT, "saturation flag without a clipped value")
   `ASSERT_CLK(a_busy_after_sample, clock, reset, req_valid && req_ready && req_operation == OP_FILTER |=> !req_ready, "sample request taken while a sample is filtered")

endmodule

bind fir_filter_bank_select_top fbs_checker u_fbs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_operation       (req_operation),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_filtered_sample (rsp_filtered_sample),
   .rsp_saturated       (rsp_saturated)
);

@@ dv/fir_filter_bank_select_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR filter bank select, block-level testbench
// Sends sample and coefficient-write requests through the valid/ready request
// channel, predicts every filter output with its own model of the three banks
// and the history line, and checks each response as it arrives. The bank
// select register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module fir_filter_bank_select_top_test;
   import fbs_pkg::*;

   localparam int TAPS      = TAPS_DEFAULT;
   localparam int BANKS     = BANKS_DEFAULT;
   localparam int FRAC_BITS = FRAC_BITS_DEFAULT;
   localparam int SETTLE    = TAPS + 16;
   localparam int QUIET_LIMIT = 4000;
   localparam logic [BANK_W-1:0] PHASE_BANKS [6] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1};

   typedef struct packed {
      op_type                     operation;
      logic signed [SAMPLE_W-1:0] sample;
      logic [BANK_W-1:0]          coef_bank;
      logic [INDEX_W-1:0]         coef_index;
      logic signed [COEF_W-1:0]   coef_value;
   } request_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       clipped;
   } filter_out_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [0:0]                 req_operation = OP_FILTER;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [BANK_W-1:0]          req_coef_bank = '0;
   logic [INDEX_W-1:0]         req_coef_index = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered_sample;
   logic                       rsp_saturated;
   logic                       csr_write_enable = 1'b0;
   logic [BANK_W-1:0]          csr_write_data = '0;

   request_type    pending[$];
   filter_out_type outputs_due[$];

   logic signed [SAMPLE_W-1:0] history [TAPS-1];
   logic signed [COEF_W-1:0]   coefs [BANKS][TAPS];
   logic [BANK_W-1:0]          active_bank = '0;

   int requests_taken = 0;
   int outputs_seen = 0;
   int mismatches = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   fir_filter_bank_select_top #(
      .TAPS(TAPS),
      .BANKS(BANKS),
      .COEF_FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_sample(req_sample),
      .req_coef_bank(req_coef_bank),
      .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_filtered_sample(rsp_filtered_sample),
      .rsp_saturated(rsp_saturated),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic filter_out_type filter_sample(logic signed [SAMPLE_W-1:0] x);
      int             bank;
      longint         acc;
      longint         quotient;
      filter_out_type result;
      bank = (active_bank >= BANKS) ? BANKS - 1 : int'(active_bank);
      acc = longint'(coefs[bank][0]) * longint'(x);
      for (int k = 1; k < TAPS; k++)
         acc += longint'(coefs[bank][k]) * longint'(history[k-1]);
      for (int k = TAPS - 2; k > 0; k--)
         history[k] = history[k-1];
      history[0] = x;
      quotient = acc / (longint'(1) << FRAC_BITS);
      result.clipped = 1'b1;
      if (quotient > 32767) begin
         result.value = 16'sh7fff;
      end else if (quotient < -32768) begin
         result.value = 16'sh8000;
      end else begin
         result.value = quotient[SAMPLE_W-1:0];
         result.clipped = 1'b0;
      end
      return result;
   endfunction

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(3))
         0, 1: return 16'($urandom);
         2: return 16'($urandom_range(511)) - 16'sd256;
         default: begin
            case ($urandom_range(3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh0000;
               default: return 16'shffff;
            endcase
         end
      endcase
   endfunction

   function automatic request_type sample_item(logic signed [SAMPLE_W-1:0] value);
      request_type item;
      item = '0;
      item.operation = OP_FILTER;
      item.sample = value;
      item.coef_bank = 2'($urandom);
      item.coef_index = 6'($urandom);
      item.coef_value = 16'($urandom);
      return item;
   endfunction

   function automatic request_type coef_write(logic [BANK_W-1:0] bank,
                                              logic [INDEX_W-1:0] index,
                                              logic signed [COEF_W-1:0] value);
      request_type item;
      item = '0;
      item.operation = OP_COEF_WRITE;
      item.sample = 16'($urandom);
      item.coef_bank = bank;
      item.coef_index = index;
      item.coef_value = value;
      return item;
   endfunction

   function automatic request_type random_request();
      logic [BANK_W-1:0]  bank;
      logic [INDEX_W-1:0] index;
      if ($urandom_range(99) < 18) begin
         bank = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(BANKS - 1));
         index = ($urandom_range(15) == 0) ? 6'd63 : 6'($urandom_range(TAPS - 1));
         return coef_write(bank, index, pick_value());
      end
      return sample_item(pick_value());
   endfunction

   task automatic settle_block();
      while (pending.size() != 0 || outputs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic select_bank(logic [BANK_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      active_bank = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin : request_driver
      logic        offer;
      request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            item = pending.pop_front();
            requests_taken++;
            if (item.operation == OP_COEF_WRITE) begin
               if (item.coef_bank < BANKS && item.coef_index < TAPS)
                  coefs[item.coef_bank][item.coef_index] = item.coef_value;
            end else begin
               outputs_due.push_back(filter_sample(item.sample));
            end
         end
         if (!offer && pending.size() != 0)
            offer = (requests_taken >= 600 && requests_taken < 750) ||
                    $urandom_range(99) >= 27;
         req_valid <= offer;
         if (offer) begin
            req_operation <= pending[0].operation;
            req_sample <= pending[0].sample;
            req_coef_bank <= pending[0].coef_bank;
            req_coef_index <= pending[0].coef_index;
            req_coef_value <= pending[0].coef_value;
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      filter_out_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            outputs_seen++;
            if (outputs_due.size() == 0) begin
               $display("%0t: unexpected response, filtered_sample %0d saturated %0b",
                        $time, rsp_filtered_sample, rsp_saturated);
               mismatches++;
            end else begin
               want = outputs_due.pop_front();
               if (rsp_filtered_sample !== want.value) begin
                  $display("%0t: filtered_sample expected %0d actual %0d",
                           $time, want.value, rsp_filtered_sample);
                  mismatches++;
               end
               if (rsp_saturated !== want.clipped) begin
                  $display("%0t: saturated expected %0b actual %0b",
                           $time, want.clipped, rsp_saturated);
                  mismatches++;
               end
            end
            if (outputs_seen == 300)
               hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (outputs_seen >= 450 && outputs_seen < 600) ||
                         $urandom_range(99) >= 27;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      foreach (history[k])
         history[k] = '0;
      foreach (coefs[b, k])
         coefs[b][k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // All banks are still zero, then the most negative coefficient meets each extreme sample.
      pending.push_back(sample_item(16'sd12345));
      pending.push_back(sample_item(16'sh8000));
      pending.push_back(coef_write(2'd0, 6'd0, 16'sh8000));
      pending.push_back(coef_write(2'd0, 6'd62, 16'sh7fff));
      pending.push_back(coef_write(2'd1, 6'd0, 16'sh7fff));
      pending.push_back(coef_write(2'd2, 6'd62, 16'sh8000));
      pending.push_back(coef_write(2'd3, 6'd0, 16'sd1000));
      pending.push_back(coef_write(2'd0, 6'd63, 16'sd1000));
      pending.push_back(sample_item(16'sh8000));
      pending.push_back(sample_item(16'sh7fff));
      pending.push_back(coef_write(2'd0, 6'd1, 16'sh8000));
      pending.push_back(sample_item(16'sh7fff));
      pending.push_back(sample_item(16'sh8000));
      pending.push_back(sample_item(16'sh8000));
      pending.push_back(coef_write(2'd0, 6'd2, 16'sd3));
      pending.push_back(sample_item(-16'sd7));
      pending.push_back(sample_item(16'sd5));
      pending.push_back(sample_item(16'sd0));
      pending.push_back(sample_item(16'sd1));
      pending.push_back(sample_item(-16'sd1));

      for (int p = 0; p < 6; p++) begin
         settle_block();
         select_bank(PHASE_BANKS[p]);
         @(negedge clock);
         for (int n = 0; n < 20; n++)
            pending.push_back(coef_write(
               (PHASE_BANKS[p] >= BANKS) ? 2'(BANKS - 1) : PHASE_BANKS[p],
               6'($urandom_range(TAPS - 1)), pick_value()));
         for (int n = 0; n < 135; n++)
            pending.push_back(random_request());
      end

      settle_block();
      if (mismatches == 0 && outputs_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/fbs_pkg.sv
hw/rtl/fir_filter_bank_select_top.sv
hw/rtl/fbs_checker.sv
dv/fir_filter_bank_select_top_test.sv
